// ===== rtl/core/alil_pkg.sv =====
`default_nettype none

package alil_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int KIND_W   = 2;
	localparam int POS_W    = 7;
	localparam int VAL_W    = 8;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 7;
	localparam int LEN_W    = 7;

	typedef enum logic [KIND_W-1:0] {
		OP_INSERT   = 2'd0,
		OP_LOCATE   = 2'd1,
		OP_CLEAR    = 2'd2,
		OP_TRAVERSE = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		EM_NONE,
		EM_OK,
		EM_BAD_POS,
		EM_FULL,
		EM_NOT_FOUND,
		EM_FOUND,
		EM_ELEM
	} emit_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_SH_RD,
		S_SH_WR,
		S_INS_WR,
		S_RD,
		S_CHK
	} state_t;

	typedef struct packed {
		logic  load;
		logic  rd_prev;
		logic  shift_wr;
		logic  ins_wr;
		logic  clr;
		logic  idx_inc;
		emit_t emit;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic pos_bad;
		logic full;
		logic no_shift;
		logic len_zero;
		logic shift_last;
		logic match;
		logic at_end;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/alil_ctrl.sv =====
`default_nettype none

module alil_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	input  alil_pkg::dp_stat_t   stat,
	output logic                 busy,
	output alil_pkg::ctrl_cmd_t  cmd
);

	import alil_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_INSERT: begin
						priority if (stat.pos_bad || stat.full || stat.no_shift) begin
							state_d = S_IDLE;
						end else begin
							state_d = S_SH_RD;
						end
					end
					OP_LOCATE, OP_TRAVERSE: begin
						state_d = stat.len_zero ? S_IDLE : S_RD;
					end
					OP_CLEAR: begin
						state_d = S_IDLE;
					end
					default: begin
						state_d = S_IDLE;
					end
				endcase
			end
			S_SH_RD: begin
				state_d = S_SH_WR;
			end
			S_SH_WR: begin
				state_d = stat.shift_last ? S_INS_WR : S_SH_RD;
			end
			S_INS_WR: begin
				state_d = S_IDLE;
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (stat.at_end || (stat.op == OP_LOCATE && stat.match)) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		busy         = (state_q != S_IDLE);
		cmd          = '0;
		cmd.emit     = EM_NONE;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = start;
			end
			S_DECODE: begin
				unique case (stat.op)
					OP_INSERT: begin
						priority if (stat.pos_bad) begin
							cmd.emit = EM_BAD_POS;
						end else if (stat.full) begin
							cmd.emit = EM_FULL;
						end else if (stat.no_shift) begin
							cmd.ins_wr = 1'b1;
							cmd.emit   = EM_OK;
						end else begin
							cmd.emit = EM_NONE;
						end
					end
					OP_LOCATE: begin
						if (stat.len_zero) begin
							cmd.emit = EM_NOT_FOUND;
						end
					end
					OP_CLEAR: begin
						cmd.clr  = 1'b1;
						cmd.emit = EM_OK;
					end
					OP_TRAVERSE: begin
						if (stat.len_zero) begin
							cmd.emit = EM_OK;
						end
					end
					default: begin
						cmd.emit = EM_NONE;
					end
				endcase
			end
			S_SH_RD: begin
				cmd.rd_prev = 1'b1;
			end
			S_SH_WR: begin
				cmd.shift_wr = 1'b1;
			end
			S_INS_WR: begin
				cmd.ins_wr = 1'b1;
				cmd.emit   = EM_OK;
			end
			S_RD: begin
				cmd.emit = EM_NONE;
			end
			S_CHK: begin
				if (stat.op == OP_LOCATE) begin
					priority if (stat.match) begin
						cmd.emit = EM_FOUND;
					end else if (stat.at_end) begin
						cmd.emit = EM_NOT_FOUND;
					end else begin
						cmd.idx_inc = 1'b1;
					end
				end else begin
					cmd.emit    = EM_ELEM;
					cmd.idx_inc = !stat.at_end;
				end
			end
			default: begin
				cmd.emit = EM_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/alil_dp.sv =====
`default_nettype none

module alil_dp #(
	parameter int CAPACITY = alil_pkg::CAPACITY_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire  [alil_pkg::KIND_W-1:0]       kind,
	input  wire  [alil_pkg::POS_W-1:0]        position,
	input  wire  [alil_pkg::VAL_W-1:0]        value,
	input  alil_pkg::ctrl_cmd_t               cmd,
	output alil_pkg::dp_stat_t                stat,
	output logic                              result_valid,
	output logic [alil_pkg::STATUS_W-1:0]     status,
	output logic [alil_pkg::INDEX_W-1:0]      found_index,
	output logic [alil_pkg::VAL_W-1:0]        element,
	output logic                              has_element,
	output logic [alil_pkg::LEN_W-1:0]        current_length,
	output logic                              last
);

	import alil_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);

	logic [VAL_W-1:0] mem [CAPACITY];

	op_t              op_q;
	logic [POS_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [LW-1:0]    len_q;
	logic [LW-1:0]    idx_q;
	logic [VAL_W-1:0] rd_q;

	logic [LW-1:0]    len_next;
	logic [LW-1:0]    idx_p1;
	logic [LW-1:0]    idx_m1;
	logic [POS_W:0]   len_p1_w;
	logic [POS_W-1:0] pos_m1;
	logic [AW-1:0]    rd_addr;

	logic                result_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [INDEX_W-1:0]  found_index_q;
	logic [VAL_W-1:0]    element_q;
	logic                has_element_q;
	logic [LEN_W-1:0]    current_length_q;
	logic                last_q;

	assign idx_p1   = idx_q + LW'(1);
	assign idx_m1   = idx_q - LW'(1);
	assign len_p1_w = (POS_W + 1)'(len_q) + (POS_W + 1)'(1);
	assign pos_m1   = pos_q - POS_W'(1);
	assign rd_addr  = cmd.rd_prev ? idx_m1[AW-1:0] : idx_q[AW-1:0];

	always_comb begin
		priority if (cmd.clr) begin
			len_next = '0;
		end else if (cmd.ins_wr) begin
			len_next = len_q + LW'(1);
		end else begin
			len_next = len_q;
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.pos_bad    = (pos_q == '0) || ({1'b0, pos_q} > len_p1_w);
		stat.full       = (len_q == LW'(CAPACITY));
		stat.no_shift   = ({1'b0, pos_q} == len_p1_w);
		stat.len_zero   = (len_q == '0);
		stat.shift_last = (POS_W'(idx_q) == pos_q);
		stat.match      = (rd_q == val_q);
		stat.at_end     = (idx_p1 == len_q);
	end

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.shift_wr) begin
			mem[idx_q[AW-1:0]] <= rd_q;
		end else if (cmd.ins_wr) begin
			mem[pos_m1[AW-1:0]] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(kind);
			pos_q <= position;
			val_q <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			idx_q <= '0;
		end else begin
			len_q <= len_next;
			priority if (cmd.load) begin
				idx_q <= (op_t'(kind) == OP_INSERT) ? len_q : '0;
			end else if (cmd.shift_wr) begin
				idx_q <= idx_m1;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (cmd.emit != EM_NONE);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit != EM_NONE) begin
			status_q         <= ST_OK;
			found_index_q    <= '0;
			element_q        <= '0;
			has_element_q    <= 1'b0;
			current_length_q <= LEN_W'(len_next);
			last_q           <= 1'b1;
			unique case (cmd.emit)
				EM_BAD_POS: begin
					status_q <= ST_BAD_POS;
				end
				EM_FULL: begin
					status_q <= ST_FULL;
				end
				EM_NOT_FOUND: begin
					status_q <= ST_NOT_FOUND;
				end
				EM_FOUND: begin
					found_index_q <= INDEX_W'(idx_p1);
				end
				EM_ELEM: begin
					element_q     <= rd_q;
					has_element_q <= 1'b1;
					last_q        <= stat.at_end;
				end
				default: begin
					status_q <= ST_OK;
				end
			endcase
		end
	end

	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign found_index    = found_index_q;
	assign element        = element_q;
	assign has_element    = has_element_q;
	assign current_length = current_length_q;
	assign last           = last_q;

endmodule

`default_nettype wire

// ===== rtl/core/array_list_insert_locate_top.sv =====
// One item at a time; start is taken when busy is low, results cannot be stalled.
// Clear, rejected inserts and inserts at the tail finish in the decode state. Other inserts
// shift each element from the position on up one place (read, then write), then insert.
// Locate and traverse read and check the elements in order; traverse emits one beat per element.
// Asynchronous active-low reset empties the list; element memory is not cleared.
`default_nettype none

module array_list_insert_locate_top #(
	parameter int CAPACITY = alil_pkg::CAPACITY_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire  [alil_pkg::KIND_W-1:0]       kind,
	input  wire  [alil_pkg::POS_W-1:0]        position,
	input  wire  [alil_pkg::VAL_W-1:0]        value,
	output logic                              result_valid,
	output logic [alil_pkg::STATUS_W-1:0]     status,
	output logic [alil_pkg::INDEX_W-1:0]      found_index,
	output logic [alil_pkg::VAL_W-1:0]        element,
	output logic                              has_element,
	output logic [alil_pkg::LEN_W-1:0]        current_length,
	output logic                              last
);

	import alil_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	alil_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	alil_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.kind           (kind),
		.position       (position),
		.value          (value),
		.cmd            (cmd),
		.stat           (stat),
		.result_valid   (result_valid),
		.status         (status),
		.found_index    (found_index),
		.element        (element),
		.has_element    (has_element),
		.current_length (current_length),
		.last           (last)
	);

endmodule

`default_nettype wire
